>>> rtl/right_cauchy_green_tensor_assert.svh
// Assertion macros for the right Cauchy-Green tensor block.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef RIGHT_CAUCHY_GREEN_TENSOR_ASSERT_SVH
`define RIGHT_CAUCHY_GREEN_TENSOR_ASSERT_SVH

// Checked only out of reset.
`define RCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset as well.
`define RCG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rcg_pkg.sv
// Shared sizes, stage payload types and index helpers for the tensor pipeline.
// No dependencies; imported by every rcg module and the top level.
package rcg_pkg;

  localparam int IN_WIDTH  = 16;
  localparam int FRAC_BITS = 12;
  localparam int OUT_WIDTH = 24;
  localparam int N_DIM     = 3;
  localparam int N_ELEM    = N_DIM * N_DIM;
  localparam int N_UNIQ    = 6;
  localparam int PROD_W    = 2 * IN_WIDTH;
  localparam int LIN_W     = IN_WIDTH + 1;
  localparam int SUM_W     = ((2 * IN_WIDTH + 2) > (FRAC_BITS + OUT_WIDTH)) ?
                             (2 * IN_WIDTH + 2) : (FRAC_BITS + OUT_WIDTH);

  typedef logic signed [IN_WIDTH-1:0]  elem_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [LIN_W-1:0]     lin_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic signed [OUT_WIDTH-1:0] res_t;

  localparam sum_t ONE_FIX = sum_t'(SUM_W'(1) << FRAC_BITS);

  typedef struct {
    elem_t f [N_ELEM];
    logic  last;
    logic  lin_mode;
  } grad_t;

  typedef struct {
    prod_t prod [N_UNIQ][N_DIM];
    lin_t  lin  [N_UNIQ];
    logic  last;
    logic  lin_mode;
  } prod_stage_t;

  typedef struct {
    sum_t sum [N_UNIQ];
    lin_t lin [N_UNIQ];
    logic last;
    logic lin_mode;
  } sum_stage_t;

  typedef struct {
    res_t c [N_UNIQ];
    logic last;
  } res_stage_t;

  // C is symmetric: upper-triangle entries in row-major order.
  function automatic int uniq_row(input int u);
    int r;
    case (u)
      0, 1, 2: r = 0;
      3, 4:    r = 1;
      default: r = 2;
    endcase
    return r;
  endfunction

  function automatic int uniq_col(input int u);
    int c;
    case (u)
      0:       c = 0;
      1, 3:    c = 1;
      default: c = 2;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/right_cauchy_green_tensor.sv
// Right Cauchy-Green tensor C = F^T F, or F + F^T - I, of one 3x3 gradient.
// Three registered stages from input to output transaction: multiply, add, select.
// Throughput: one gradient per cycle while out_stall is low; each of the three stages holds one item.
// Reset (rst_n low, synchronous): pipeline emptied, linearized_mode cleared to 0.
// Depends on rcg_pkg, rcg_mult, rcg_sum, rcg_out, right_cauchy_green_tensor_assert.svh.
`include "right_cauchy_green_tensor_assert.svh"

module right_cauchy_green_tensor
  import rcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_linearized_mode,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [IN_WIDTH-1:0] in_f_r0c0,
  input  logic signed [IN_WIDTH-1:0] in_f_r0c1,
  input  logic signed [IN_WIDTH-1:0] in_f_r0c2,
  input  logic signed [IN_WIDTH-1:0] in_f_r1c0,
  input  logic signed [IN_WIDTH-1:0] in_f_r1c1,
  input  logic signed [IN_WIDTH-1:0] in_f_r1c2,
  input  logic signed [IN_WIDTH-1:0] in_f_r2c0,
  input  logic signed [IN_WIDTH-1:0] in_f_r2c1,
  input  logic signed [IN_WIDTH-1:0] in_f_r2c2,
  input  logic        in_batch_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [OUT_WIDTH-1:0] out_c_r0c0,
  output logic signed [OUT_WIDTH-1:0] out_c_r0c1,
  output logic signed [OUT_WIDTH-1:0] out_c_r0c2,
  output logic signed [OUT_WIDTH-1:0] out_c_r1c0,
  output logic signed [OUT_WIDTH-1:0] out_c_r1c1,
  output logic signed [OUT_WIDTH-1:0] out_c_r1c2,
  output logic signed [OUT_WIDTH-1:0] out_c_r2c0,
  output logic signed [OUT_WIDTH-1:0] out_c_r2c1,
  output logic signed [OUT_WIDTH-1:0] out_c_r2c2,
  output logic        out_batch_done
);

  logic        mode_r;
  grad_t       in_data;
  logic        s1_ready;
  logic        s1_valid;
  prod_stage_t s1_data;
  logic        s2_ready;
  logic        s2_valid;
  sum_stage_t  s2_data;
  logic        s3_ready;
  res_stage_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_linearized_mode;
    end
  end

  always_comb begin
    in_data.f[0]    = in_f_r0c0;
    in_data.f[1]    = in_f_r0c1;
    in_data.f[2]    = in_f_r0c2;
    in_data.f[3]    = in_f_r1c0;
    in_data.f[4]    = in_f_r1c1;
    in_data.f[5]    = in_f_r1c2;
    in_data.f[6]    = in_f_r2c0;
    in_data.f[7]    = in_f_r2c1;
    in_data.f[8]    = in_f_r2c2;
    in_data.last     = in_batch_end;
    in_data.lin_mode = mode_r;
  end

  assign in_stall = !s1_ready;

  rcg_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (s1_ready),
    .up_data  (in_data),
    .dn_valid (s1_valid),
    .dn_ready (s2_ready),
    .dn_data  (s1_data)
  );

  rcg_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s3_ready),
    .dn_data  (s2_data)
  );

  rcg_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s3_ready),
    .up_data  (s2_data),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_data  (res)
  );

  // mirror the upper triangle into the full tensor
  assign out_c_r0c0     = res.c[0];
  assign out_c_r0c1     = res.c[1];
  assign out_c_r0c2     = res.c[2];
  assign out_c_r1c0     = res.c[1];
  assign out_c_r1c1     = res.c[3];
  assign out_c_r1c2     = res.c[4];
  assign out_c_r2c0     = res.c[2];
  assign out_c_r2c1     = res.c[4];
  assign out_c_r2c2     = res.c[5];
  assign out_batch_done = res.last;

  `RCG_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid && !s1_valid && !s2_valid, "pipeline not empty after reset")
  `RCG_ASSERT(a_accept_enters, in_valid && !in_stall |=> s1_valid, "accepted transaction not captured in stage 1")
  `RCG_ASSERT(a_stall_only_full, in_stall |-> s1_valid && s2_valid && out_valid, "input stalled with a free stage")
  `RCG_ASSERT(a_no_phantom, out_valid && !out_stall && !s2_valid |=> !out_valid, "output transaction without a source item")

endmodule

>>> rtl/rcg_mult.sv
// Stage 1: the 18 products of F^T F and the F + F^T terms, registered.
// Depends on rcg_pkg.
module rcg_mult
  import rcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  grad_t       up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output prod_stage_t dn_data
);

  logic        valid_r;
  prod_stage_t data_r;
  prod_stage_t data_nxt;
  prod_t       prod_nxt [N_UNIQ][N_DIM];
  lin_t        lin_nxt  [N_UNIQ];

  for (genvar u = 0; u < N_UNIQ; u++) begin : g_uniq
    localparam int J = uniq_row(u);
    localparam int K = uniq_col(u);
    for (genvar l = 0; l < N_DIM; l++) begin : g_term
      assign prod_nxt[u][l] = up_data.f[l*N_DIM+J] * up_data.f[l*N_DIM+K];
    end
    assign lin_nxt[u] = LIN_W'(up_data.f[J*N_DIM+K]) + LIN_W'(up_data.f[K*N_DIM+J]);
  end

  always_comb begin
    data_nxt.prod     = prod_nxt;
    data_nxt.lin      = lin_nxt;
    data_nxt.last     = up_data.last;
    data_nxt.lin_mode = up_data.lin_mode;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> rtl/rcg_sum.sv
// Stage 2: sums the three products of each tensor entry, registered.
// Depends on rcg_pkg.
module rcg_sum
  import rcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  prod_stage_t up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output sum_stage_t  dn_data
);

  logic       valid_r;
  sum_stage_t data_r;
  sum_stage_t data_nxt;
  sum_t       sum_nxt [N_UNIQ];

  for (genvar u = 0; u < N_UNIQ; u++) begin : g_uniq
    assign sum_nxt[u] = SUM_W'(up_data.prod[u][0]) + SUM_W'(up_data.prod[u][1])
                      + SUM_W'(up_data.prod[u][2]);
  end

  always_comb begin
    data_nxt.sum      = sum_nxt;
    data_nxt.lin      = up_data.lin;
    data_nxt.last     = up_data.last;
    data_nxt.lin_mode = up_data.lin_mode;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> rtl/rcg_out.sv
// Stage 3: rescale or subtract identity, select by mode, output register.
// Depends on rcg_pkg.
module rcg_out
  import rcg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  sum_stage_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output res_stage_t dn_data
);

  logic       valid_r;
  res_stage_t data_r;
  res_stage_t data_nxt;
  res_t       c_nxt [N_UNIQ];
  sum_t       lin_full [N_UNIQ];

  for (genvar u = 0; u < N_UNIQ; u++) begin : g_uniq
    if (uniq_row(u) == uniq_col(u)) begin : g_diag
      assign lin_full[u] = SUM_W'(up_data.lin[u]) - ONE_FIX;
    end else begin : g_off
      assign lin_full[u] = SUM_W'(up_data.lin[u]);
    end
    assign c_nxt[u] = up_data.lin_mode ? lin_full[u][OUT_WIDTH-1:0]
                                       : up_data.sum[u][FRAC_BITS +: OUT_WIDTH];
  end

  always_comb begin
    data_nxt.c    = c_nxt;
    data_nxt.last = up_data.last;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> test/right_cauchy_green_tensor_tb.sv
// Self-checking testbench for right_cauchy_green_tensor: directed table, then random gradients.
// Predicts F^T F or F + F^T - I per transaction, or takes it from the directed table, and checks every result in order.
// Depends on rcg_pkg and the right_cauchy_green_tensor RTL.
`timescale 1ns / 100ps

module right_cauchy_green_tensor_tb
  import rcg_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int PIPE_DEPTH  = 3;
  localparam int N_DIRECTED  = 13;
  localparam int N_RANDOM    = 400;

  typedef logic [N_ELEM-1:0][IN_WIDTH-1:0] grad_vec_t;

  typedef struct packed {
    logic done;
    logic [N_ELEM-1:0][OUT_WIDTH-1:0] c;
  } tensor_t;

  typedef struct packed {
    logic      lin;
    logic      last;
    logic      has_exp;
    grad_vec_t f;
    tensor_t   c_exp;
  } grad_row_t;

  localparam logic [IN_WIDTH-1:0] ONE_F  = IN_WIDTH'(1 << FRAC_BITS);
  localparam logic [IN_WIDTH-1:0] ZERO_F = '0;
  localparam grad_vec_t IDENT_F = {ONE_F, ZERO_F, ZERO_F, ZERO_F, ONE_F,
                                   ZERO_F, ZERO_F, ZERO_F, ONE_F};

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_linearized_mode;
  logic in_valid;
  logic in_stall;
  logic signed [IN_WIDTH-1:0] in_f_r0c0, in_f_r0c1, in_f_r0c2;
  logic signed [IN_WIDTH-1:0] in_f_r1c0, in_f_r1c1, in_f_r1c2;
  logic signed [IN_WIDTH-1:0] in_f_r2c0, in_f_r2c1, in_f_r2c2;
  logic in_batch_end;
  logic out_valid;
  logic out_stall;
  logic signed [OUT_WIDTH-1:0] out_c_r0c0, out_c_r0c1, out_c_r0c2;
  logic signed [OUT_WIDTH-1:0] out_c_r1c0, out_c_r1c1, out_c_r1c2;
  logic signed [OUT_WIDTH-1:0] out_c_r2c0, out_c_r2c1, out_c_r2c2;
  logic out_batch_done;

  tensor_t   pending_c_q [$];
  grad_row_t dir_rows [N_DIRECTED];
  logic      lin_mode;
  bit        steady;
  int        err_count;
  int        cycle_count;

  right_cauchy_green_tensor dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_linearized_mode (cfg_linearized_mode),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_f_r0c0           (in_f_r0c0),
    .in_f_r0c1           (in_f_r0c1),
    .in_f_r0c2           (in_f_r0c2),
    .in_f_r1c0           (in_f_r1c0),
    .in_f_r1c1           (in_f_r1c1),
    .in_f_r1c2           (in_f_r1c2),
    .in_f_r2c0           (in_f_r2c0),
    .in_f_r2c1           (in_f_r2c1),
    .in_f_r2c2           (in_f_r2c2),
    .in_batch_end        (in_batch_end),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_c_r0c0          (out_c_r0c0),
    .out_c_r0c1          (out_c_r0c1),
    .out_c_r0c2          (out_c_r0c2),
    .out_c_r1c0          (out_c_r1c0),
    .out_c_r1c1          (out_c_r1c1),
    .out_c_r1c2          (out_c_r1c2),
    .out_c_r2c0          (out_c_r2c0),
    .out_c_r2c1          (out_c_r2c1),
    .out_c_r2c2          (out_c_r2c2),
    .out_batch_done      (out_batch_done)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic tensor_t cauchy_green(input logic lin, input grad_vec_t f,
                                           input logic last);
    longint  fv [N_ELEM];
    longint  acc;
    tensor_t t;
    for (int i = 0; i < N_ELEM; i++) begin
      fv[i] = $signed(f[i]);
    end
    for (int j = 0; j < N_DIM; j++) begin
      for (int k = 0; k < N_DIM; k++) begin
        if (lin) begin
          acc = fv[j*N_DIM+k] + fv[k*N_DIM+j];
          if (j == k) acc = acc - (longint'(1) << FRAC_BITS);
        end else begin
          acc = 0;
          for (int l = 0; l < N_DIM; l++) begin
            acc = acc + fv[l*N_DIM+j] * fv[l*N_DIM+k];
          end
          acc = acc >>> FRAC_BITS;
        end
        t.c[j*N_DIM+k] = acc[OUT_WIDTH-1:0];
      end
    end
    t.done = last;
    return t;
  endfunction

  function automatic tensor_t flat_c(input int diag_v, input int off_v, input logic done);
    tensor_t t;
    for (int i = 0; i < N_ELEM; i++) begin
      t.c[i] = (i % (N_DIM + 1) == 0) ? diag_v[OUT_WIDTH-1:0] : off_v[OUT_WIDTH-1:0];
    end
    t.done = done;
    return t;
  endfunction

  function automatic grad_row_t mk_row(input logic lin, input logic last, input logic has_exp,
                                       input grad_vec_t f, input tensor_t c_exp);
    grad_row_t r;
    r.lin     = lin;
    r.last    = last;
    r.has_exp = has_exp;
    r.f       = f;
    r.c_exp   = c_exp;
    return r;
  endfunction

  function automatic logic [IN_WIDTH-1:0] rand_elem();
    logic [IN_WIDTH-1:0] v;
    logic [31:0]         w;
    w = $urandom();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(IN_WIDTH-1){1'b0}}};
          1: v = {1'b0, {(IN_WIDTH-1){1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      1, 2, 3: v = IN_WIDTH'($urandom_range(0, 4095)) - IN_WIDTH'(2048);
      4: v = ONE_F + IN_WIDTH'($urandom_range(0, 4095)) - IN_WIDTH'(2048);
      default: v = w[IN_WIDTH-1:0];
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_c_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 1) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    wait_drained();
    cfg_valid           <= 1'b1;
    cfg_linearized_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    lin_mode = m;
  endtask

  task automatic send_grad(input grad_vec_t f, input logic last, input logic has_exp,
                           input tensor_t c_exp);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_f_r0c0    <= f[0];
    in_f_r0c1    <= f[1];
    in_f_r0c2    <= f[2];
    in_f_r1c0    <= f[3];
    in_f_r1c1    <= f[4];
    in_f_r1c2    <= f[5];
    in_f_r2c0    <= f[6];
    in_f_r2c1    <= f[7];
    in_f_r2c2    <= f[8];
    in_batch_end <= last;
    do @(posedge clk); while (in_stall);
    pending_c_q.push_back(has_exp ? c_exp : cauchy_green(lin_mode, f, last));
  endtask

  // result side: check each transaction, then hold stall at random, never in steady mode
  initial begin
    tensor_t got;
    tensor_t want;
    int      stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        got.c = {out_c_r2c2, out_c_r2c1, out_c_r2c0, out_c_r1c2, out_c_r1c1,
                 out_c_r1c0, out_c_r0c2, out_c_r0c1, out_c_r0c0};
        got.done = out_batch_done;
        if (pending_c_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected result transaction, nothing pending");
        end else begin
          want = pending_c_q.pop_front();
          for (int i = 0; i < N_ELEM; i++) begin
            if (got.c[i] !== want.c[i]) begin
              err_count++;
              if (err_count <= 10)
                $display("c[%0d] mismatch: expected %0d, got %0d", i,
                         $signed(want.c[i]), $signed(got.c[i]));
            end
          end
          if (got.done !== want.done) begin
            err_count++;
            if (err_count <= 10)
              $display("batch_done mismatch: expected %0b, got %0b", want.done, got.done);
          end
        end
        stall_left = steady ? 0 : $urandom_range(0, 3);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  initial begin
    grad_vec_t f;
    logic      last;
    tensor_t   none;
    none         = '0;
    steady       = 1'b0;
    lin_mode     = 1'b0;
    rst_n               <= 1'b0;
    cfg_valid           <= 1'b0;
    cfg_linearized_mode <= 1'b0;
    in_valid            <= 1'b0;
    in_f_r0c0 <= '0; in_f_r0c1 <= '0; in_f_r0c2 <= '0;
    in_f_r1c0 <= '0; in_f_r1c1 <= '0; in_f_r1c2 <= '0;
    in_f_r2c0 <= '0; in_f_r2c1 <= '0; in_f_r2c2 <= '0;
    in_batch_end <= 1'b0;

    dir_rows[0]  = mk_row(1'b0, 1'b0, 1'b1, '0, flat_c(0, 0, 1'b0));
    dir_rows[1]  = mk_row(1'b0, 1'b1, 1'b1, IDENT_F, flat_c(4096, 0, 1'b1));
    dir_rows[2]  = mk_row(1'b0, 1'b1, 1'b1, {N_ELEM{16'h8000}}, flat_c(786432, 786432, 1'b1));
    dir_rows[3]  = mk_row(1'b0, 1'b0, 1'b1, {N_ELEM{16'h7FFF}}, flat_c(786384, 786384, 1'b0));
    dir_rows[4]  = mk_row(1'b0, 1'b0, 1'b0, {16'h8000, 16'h7FFF, 16'hF000, 16'h1000,
                          16'h0001, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF}, none);
    dir_rows[5]  = mk_row(1'b0, 1'b1, 1'b0, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                          16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, none);
    dir_rows[6]  = mk_row(1'b0, 1'b0, 1'b0, {16'h1000, 16'h0800, 16'h0000, 16'h0000,
                          16'h1000, 16'h0000, 16'hFC00, 16'h0000, 16'h1200}, none);
    dir_rows[7]  = mk_row(1'b1, 1'b0, 1'b1, '0, flat_c(-4096, 0, 1'b0));
    dir_rows[8]  = mk_row(1'b1, 1'b1, 1'b1, IDENT_F, flat_c(4096, 0, 1'b1));
    dir_rows[9]  = mk_row(1'b1, 1'b0, 1'b1, {N_ELEM{16'h8000}}, flat_c(-69632, -65536, 1'b0));
    dir_rows[10] = mk_row(1'b1, 1'b1, 1'b1, {N_ELEM{16'h7FFF}}, flat_c(61438, 65534, 1'b1));
    dir_rows[11] = mk_row(1'b1, 1'b0, 1'b0, {16'h8000, 16'h7FFF, 16'hF000, 16'h1000,
                          16'h0001, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF}, none);
    dir_rows[12] = mk_row(1'b1, 1'b1, 1'b0, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                          16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, none);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].lin != lin_mode) set_mode(dir_rows[r].lin);
      send_grad(dir_rows[r].f, dir_rows[r].last, dir_rows[r].has_exp, dir_rows[r].c_exp);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % (N_RANDOM / 4) == 0) set_mode(n / (N_RANDOM / 4) % 2 == 0);
      if (n % 50 == 0) steady = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 39) == 0) wait_drained();
      for (int i = 0; i < N_ELEM; i++) f[i] = rand_elem();
      last = ($urandom_range(0, 7) == 0);
      send_grad(f, last, 1'b0, none);
    end

    wait_drained();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
